### hdl/sfsa_pkg.sv
// shared types, codes and constants of the slab free-slot allocator
package sfsa_pkg;

	localparam int MAX_SLOTS_DEF = 1024;
	localparam logic [10:0] SLOT_COUNT_RST = 11'd1024;

	// command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_FORMAT  = 2'd2;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_EMPTY   = 2'd1;
	localparam logic [1:0] STS_RANGE   = 2'd2;
	localparam logic [1:0] STS_FREE    = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [9:0] slot;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  granted_slot;
		logic [10:0] free_slots;
	} out_word_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_stat_t;

endpackage

### hdl/sfsa_engine.sv
// free ring and in-use memories with the read-modify-write sequencer
module sfsa_engine #(
	parameter int MAX_SLOTS = sfsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           stall,
	input  sfsa_pkg::in_word_t             word,
	input  logic [$clog2(MAX_SLOTS+1)-1:0] eff_count,
	output sfsa_pkg::eng_stat_t            stat,
	output sfsa_pkg::out_word_t            res
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int CMPW = (CW > 10) ? CW : 10;
	localparam logic [CW-1:0] TOTAL_RST = CW'((MAX_SLOTS < 1024) ? MAX_SLOTS : 1024);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SLOTS - 1);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} eng_state_t;

	eng_state_t state_q;
	logic [AW-1:0] clr_idx_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] total_q;
	logic [1:0]    cmd_q;
	logic [9:0]    slot_q;

	logic [AW-1:0] ring_mem [MAX_SLOTS];
	logic          used_mem [MAX_SLOTS];
	logic [AW-1:0] ring_rd_s1;
	logic          used_rd_s1;

	logic          go;
	logic [AW-1:0] slot_addr;
	logic [AW-1:0] slot_addr_q;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic          ring_we;
	logic [AW-1:0] ring_waddr;
	logic [AW-1:0] ring_wdata;
	logic          used_we;
	logic [AW-1:0] used_waddr;
	logic          used_wdata;
	logic [1:0]    status;
	logic [CW-1:0] total_nxt;
	logic [9:0]    granted;
	logic          alloc_ok;
	logic          release_ok;
	logic          is_format;

	assign slot_addr = AW'(word.slot);
	assign slot_addr_q = AW'(slot_q);
	assign go = (state_q == S_EXEC) && !stall;

	// tail sits free_total entries past the head
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(total_q);
	assign tail = (tail_sum >= (CW+1)'(MAX_SLOTS)) ? AW'(tail_sum - (CW+1)'(MAX_SLOTS))
		: AW'(tail_sum);

	always_comb begin
		status = sfsa_pkg::STS_OK;
		total_nxt = total_q;
		granted = '0;
		alloc_ok = 1'b0;
		release_ok = 1'b0;
		is_format = 1'b0;
		case (cmd_q)
			sfsa_pkg::CMD_ALLOC: begin
				if (total_q == '0) begin
					status = sfsa_pkg::STS_EMPTY;
				end else begin
					alloc_ok = 1'b1;
					granted = 10'(ring_rd_s1);
					total_nxt = total_q - 1'b1;
				end
			end
			sfsa_pkg::CMD_RELEASE: begin
				if (CMPW'(slot_q) >= CMPW'(eff_count)) begin
					status = sfsa_pkg::STS_RANGE;
				end else if (!used_rd_s1) begin
					status = sfsa_pkg::STS_FREE;
				end else begin
					release_ok = 1'b1;
					total_nxt = total_q + 1'b1;
				end
			end
			sfsa_pkg::CMD_FORMAT: begin
				is_format = 1'b1;
				total_nxt = eff_count;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ring_we = 1'b0;
		ring_waddr = clr_idx_q;
		ring_wdata = clr_idx_q;
		used_we = 1'b0;
		used_waddr = clr_idx_q;
		used_wdata = 1'b0;
		if (state_q == S_CLEAR) begin
			ring_we = 1'b1;
			used_we = 1'b1;
		end else if (go && alloc_ok) begin
			used_we = 1'b1;
			used_waddr = ring_rd_s1;
			used_wdata = 1'b1;
		end else if (go && release_ok) begin
			ring_we = 1'b1;
			ring_waddr = tail;
			ring_wdata = slot_addr_q;
			used_we = 1'b1;
			used_waddr = slot_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (used_we) begin
			used_mem[used_waddr] <= used_wdata;
		end
		if (start) begin
			ring_rd_s1 <= ring_mem[head_q];
			used_rd_s1 <= used_mem[slot_addr];
			cmd_q <= word.cmd;
			slot_q <= word.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_idx_q <= '0;
			head_q <= '0;
			total_q <= TOTAL_RST;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						total_q <= total_nxt;
						if (alloc_ok) begin
							head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
						end
						if (is_format) begin
							head_q <= '0;
							clr_idx_q <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.ready = (state_q == S_IDLE);
	assign stat.res_valid = go;
	assign res.status = status;
	assign res.granted_slot = granted;
	assign res.free_slots = 11'(total_nxt);

endmodule

### hdl/slab_free_slot_allocator_top.sv
// top level of the slab free-slot allocator: handshakes, config register, result register
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_ready  | cmd, slot
//  out     | output    | out_valid/out_ready| status, granted_slot, free_slots
//  cfg     | input     | cfg_we             | slot_count (11 bits)
//
// each word has a memory read step, then a modify/write-back step.
// format and reset run a clearing pass over all MAX_SLOTS entries of both memories,
// one entry a cycle, with in_ready low; the format result is shown at its start.
// a full result register holds the write-back cycle until out_ready; a new word
// is still taken while a finished result waits.
module slab_free_slot_allocator_top #(
	parameter int MAX_SLOTS = sfsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfsa_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sfsa_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata
);

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int EW = (CW > 11) ? CW : 11;

	logic [10:0]         slot_count_q;
	logic [CW-1:0]       eff_count;
	logic                out_valid_q;
	sfsa_pkg::out_word_t out_data_q;
	sfsa_pkg::out_word_t res;
	sfsa_pkg::eng_stat_t stat;
	logic                start;
	logic                stall;

	// count saturates at the slab size
	assign eff_count = (EW'(slot_count_q) > EW'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
		: CW'(slot_count_q);

	assign start = in_valid && stat.ready;
	assign stall = out_valid_q && !out_ready;

	sfsa_engine #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.stall     (stall),
		.word      (in_data),
		.eff_count (eff_count),
		.stat      (stat),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= sfsa_pkg::SLOT_COUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_wdata;
			end
			if (stat.res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			out_data_q <= res;
		end
	end

	assign in_ready = stat.ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
